FILE: rtl/pid_pkg.sv
package pid_pkg;

    // fixed field widths
    localparam int Q_W    = 32;   // Q16.16 values and gains
    localparam int ERR_W  = 33;   // error, Q17.16
    localparam int DIFF_W = 34;   // error difference
    localparam int IVL_W  = 20;   // sample interval, Q4.16
    localparam int ACC_W  = 48;   // integral and product terms
    localparam int LIM_W  = 31;   // integral clamp
    localparam int NUM_W  = 50;   // divider numerator magnitude
    localparam int SUM_W  = 50;   // three-term sum
    localparam int FRAC_W = 16;   // fraction bits

    // configuration register indexes
    localparam logic [2:0] REG_GAIN_PROP  = 3'd0;
    localparam logic [2:0] REG_GAIN_INTEG = 3'd1;
    localparam logic [2:0] REG_GAIN_DERIV = 3'd2;
    localparam logic [2:0] REG_OUT_MIN    = 3'd3;
    localparam logic [2:0] REG_OUT_MAX    = 3'd4;
    localparam logic [2:0] REG_INTEG_LIM  = 3'd5;

    // request kinds on tuser
    localparam logic FUNC_COMPUTE = 1'b0;
    localparam logic FUNC_RESET   = 1'b1;

endpackage

FILE: rtl/pid_mul.sv
// bit-serial signed multiplier, result floor(a*b / 2^16) saturated to 48 bits
module pid_mul (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic signed [pid_pkg::Q_W-1:0]      a,
    input  logic signed [pid_pkg::ACC_W-1:0]    b,
    output logic                                done,
    output logic signed [pid_pkg::ACC_W-1:0]    res
);

    localparam int B_W    = pid_pkg::ACC_W;
    localparam int H_W    = pid_pkg::Q_W + 2;
    localparam int F_W    = H_W + B_W;
    localparam int S_W    = F_W - pid_pkg::FRAC_W;
    localparam logic [5:0] LAST = 6'(B_W - 1);

    logic signed [pid_pkg::Q_W-1:0] a_reg;
    logic signed [H_W-1:0]          hi_reg;
    logic [B_W-1:0]                 x_reg;
    logic [5:0]                     cnt_reg;
    logic                           run_reg;
    logic                           done_reg;

    logic signed [H_W-1:0] ga;
    logic signed [H_W-1:0] addend;
    logic signed [H_W-1:0] sum;
    logic [F_W-1:0]        full;
    logic [S_W-1:0]        q;

    // one multiplier bit per cycle, top bit weighs negative
    always_comb
    begin
        ga = {{2{a_reg[pid_pkg::Q_W-1]}}, a_reg};
        if (x_reg[0])
            addend = (cnt_reg == LAST) ? -ga : ga;
        else
            addend = '0;
        sum = hi_reg + addend;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == LAST)
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg  <= a;
            x_reg  <= b;
            hi_reg <= '0;
        end
        else if (run_reg)
        begin
            hi_reg <= sum >>> 1;
            x_reg  <= {sum[0], x_reg[B_W-1:1]};
        end
    end

    // drop fraction and saturate
    always_comb
    begin
        full = {hi_reg, x_reg};
        q    = full[F_W-1:pid_pkg::FRAC_W];
        if (q[S_W-1:B_W-1] == '0 || q[S_W-1:B_W-1] == '1)
            res = q[B_W-1:0];
        else if (q[S_W-1])
            res = {1'b1, {(B_W-1){1'b0}}};
        else
            res = {1'b0, {(B_W-1){1'b1}}};
    end

    assign done = done_reg;

endmodule

FILE: rtl/pid_div.sv
// restoring unsigned divider, one quotient bit per cycle
module pid_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [pid_pkg::NUM_W-1:0]  num,
    input  logic [pid_pkg::IVL_W-1:0]  den,
    output logic                       done,
    output logic [pid_pkg::NUM_W-1:0]  quo
);

    localparam int N_W = pid_pkg::NUM_W;
    localparam int D_W = pid_pkg::IVL_W;
    localparam logic [5:0] LAST = 6'(N_W - 1);

    logic [N_W-1:0] q_reg;
    logic [D_W:0]   rem_reg;
    logic [D_W-1:0] den_reg;
    logic [5:0]     cnt_reg;
    logic           run_reg;
    logic           done_reg;

    logic [D_W:0] trial;
    logic         ge;

    always_comb
    begin
        trial = {rem_reg[D_W-1:0], q_reg[N_W-1]};
        ge    = trial >= {1'b0, den_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == LAST)
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg   <= num;
            rem_reg <= '0;
            den_reg <= den;
        end
        else if (run_reg)
        begin
            rem_reg <= ge ? (trial - {1'b0, den_reg}) : trial;
            q_reg   <= {q_reg[N_W-2:0], ge};
        end
    end

    assign done = done_reg;
    assign quo  = q_reg;

endmodule

FILE: rtl/pid_speed_controller.sv
// pid speed controller, Q16.16, conditional-integration anti-windup
// input channel s_*: one request per item; tuser selects compute or reset
// output channel m_*: one result per compute request, none per reset
// config: cfg_we/cfg_index/cfg_data write one register per clock; the user must
// write only while idle, since the block itself does not enforce it
// a compute request runs the 50-step serial divider (derivative), a 48-step
// pass of the one bit-serial multiplier for error*interval, a step to clamp the
// candidate, four more 48-step passes (kp*e, kd*d, ki*candidate, ki*old
// integral) and steps to sum, decide, clamp and load the output; the next
// request is accepted only once the previous result is in the output register
// a reset request is handled while idle; a zero-interval request yields a zero drive
// only one request is in flight; s_tready is high while the block idles
// the result sits in an output register; if the receiver stalls, the next
// request is accepted and worked on, and waits before delivery until the
// register is free
// reset clears integral, previous error and configuration to defaults
module pid_speed_controller (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [87:0] s_tdata,   // measured[31:0], setpoint[63:32], interval[83:64], zero pad
    input  logic        s_tuser,   // func
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // drive[31:0]
    output logic        m_tuser,   // at_limit
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    localparam int Q_W    = pid_pkg::Q_W;
    localparam int ERR_W  = pid_pkg::ERR_W;
    localparam int DIFF_W = pid_pkg::DIFF_W;
    localparam int IVL_W  = pid_pkg::IVL_W;
    localparam int ACC_W  = pid_pkg::ACC_W;
    localparam int LIM_W  = pid_pkg::LIM_W;
    localparam int NUM_W  = pid_pkg::NUM_W;
    localparam int SUM_W  = pid_pkg::SUM_W;

    typedef enum logic [11:0] {
        ST_IDLE  = 12'b000000000001,
        ST_DIV   = 12'b000000000010,
        ST_MEI   = 12'b000000000100,
        ST_CAND  = 12'b000000001000,
        ST_MP    = 12'b000000010000,
        ST_MD    = 12'b000000100000,
        ST_MIC   = 12'b000001000000,
        ST_MIO   = 12'b000010000000,
        ST_SUM   = 12'b000100000000,
        ST_DEC   = 12'b001000000000,
        ST_CLAMP = 12'b010000000000,
        ST_OUT   = 12'b100000000000
    } state_t;

    state_t state_reg;
    logic   go_reg;

    // configuration
    logic signed [Q_W-1:0] kp_reg, ki_reg, kd_reg, min_reg, max_reg;
    logic [LIM_W-1:0]      lim_reg;

    // controller state
    logic signed [ACC_W-1:0] integ_reg;
    logic signed [ERR_W-1:0] last_err_reg;

    // working values
    logic signed [ERR_W-1:0]  e_reg;
    logic signed [DIFF_W-1:0] diff_reg;
    logic [IVL_W-1:0]         ivl_reg;
    logic signed [Q_W-1:0]    d_reg;
    logic signed [ACC_W-1:0]  ei_reg, cand_reg, tp_reg, td_reg, tic_reg, tio_reg;
    logic signed [SUM_W-1:0]  sum_reg, y_reg;
    logic signed [Q_W-1:0]    drive_reg;
    logic                     alim_reg;

    // output register
    logic        m_valid_reg;
    logic [31:0] m_data_reg;
    logic        m_user_reg;

    // request fields
    logic signed [Q_W-1:0]    in_meas, in_set;
    logic [IVL_W-1:0]         in_ivl;
    logic signed [ERR_W-1:0]  in_e;
    logic                     accept;

    // arithmetic units
    logic                    mul_start, mul_done;
    logic signed [Q_W-1:0]   mul_a;
    logic signed [ACC_W-1:0] mul_b, mul_res;
    logic                    div_start, div_done;
    logic [NUM_W-1:0]        div_num, div_quo;

    // combinational results
    logic [DIFF_W-1:0]       diff_mag;
    logic signed [Q_W-1:0]   d_sat;
    logic signed [ACC_W:0]   cand_sum;
    logic signed [ACC_W-1:0] cand_s, cand_c, lim_s;
    logic signed [SUM_W-1:0] trial, hi_w, lo_w;
    logic                    keep;
    logic signed [SUM_W-1:0] y1;
    logic                    c1;
    logic                    out_free;

    assign in_meas  = s_tdata[31:0];
    assign in_set   = s_tdata[63:32];
    assign in_ivl   = s_tdata[83:64];
    assign in_e     = ERR_W'(in_set) - ERR_W'(in_meas);
    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;

    // unit operands by state
    always_comb
    begin
        mul_a = kp_reg;
        mul_b = ACC_W'(e_reg);
        unique case (state_reg)
            ST_MEI:
            begin
                mul_a = Q_W'({1'b0, ivl_reg});
                mul_b = ACC_W'(e_reg);
            end
            ST_MD:
            begin
                mul_a = kd_reg;
                mul_b = ACC_W'(d_reg);
            end
            ST_MIC:
            begin
                mul_a = ki_reg;
                mul_b = cand_reg;
            end
            ST_MIO:
            begin
                mul_a = ki_reg;
                mul_b = integ_reg;
            end
            default:
            begin
                mul_a = kp_reg;
                mul_b = ACC_W'(e_reg);
            end
        endcase
        mul_start = go_reg && (state_reg != ST_DIV);
        div_start = go_reg && (state_reg == ST_DIV);
        diff_mag  = diff_reg[DIFF_W-1] ? DIFF_W'(-diff_reg) : DIFF_W'(diff_reg);
        div_num   = {diff_mag, {pid_pkg::FRAC_W{1'b0}}};
    end

    pid_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .res   (mul_res)
    );

    pid_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (ivl_reg),
        .done  (div_done),
        .quo   (div_quo)
    );

    // derivative sign and saturation to 32 bits
    always_comb
    begin
        if (!diff_reg[DIFF_W-1])
            d_sat = (div_quo > NUM_W'(32'h7FFF_FFFF)) ? 32'sh7FFF_FFFF
                                                     : Q_W'(div_quo);
        else
            d_sat = (div_quo > NUM_W'(33'h0_8000_0000)) ? 32'sh8000_0000
                                                       : Q_W'(-div_quo);
    end

    // candidate integral, saturated then clamped
    always_comb
    begin
        cand_sum = (ACC_W+1)'(integ_reg) + (ACC_W+1)'(ei_reg);
        if (cand_sum[ACC_W] != cand_sum[ACC_W-1])
            cand_s = cand_sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}}
                                     : {1'b0, {(ACC_W-1){1'b1}}};
        else
            cand_s = cand_sum[ACC_W-1:0];
        lim_s  = ACC_W'({1'b0, lim_reg});
        cand_c = cand_s;
        if (lim_reg != '0)
        begin
            if (cand_s > lim_s)
                cand_c = lim_s;
            if (cand_s < -lim_s)
                cand_c = -lim_s;
        end
    end

    // anti-windup decision and upper output clamp
    always_comb
    begin
        hi_w  = SUM_W'(max_reg);
        lo_w  = SUM_W'(min_reg);
        trial = sum_reg + SUM_W'(tic_reg);
        keep  = !((trial >= hi_w && e_reg > 0) || (trial <= lo_w && e_reg < 0));
        c1    = y_reg > hi_w;
        y1    = c1 ? hi_w : y_reg;
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kp_reg  <= '0;
            ki_reg  <= '0;
            kd_reg  <= '0;
            min_reg <= 32'sh8000_0000;
            max_reg <= 32'sh7FFF_FFFF;
            lim_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                pid_pkg::REG_GAIN_PROP:  kp_reg  <= cfg_data;
                pid_pkg::REG_GAIN_INTEG: ki_reg  <= cfg_data;
                pid_pkg::REG_GAIN_DERIV: kd_reg  <= cfg_data;
                pid_pkg::REG_OUT_MIN:    min_reg <= cfg_data;
                pid_pkg::REG_OUT_MAX:    max_reg <= cfg_data;
                pid_pkg::REG_INTEG_LIM:  lim_reg <= cfg_data[LIM_W-1:0];
                default: ;
            endcase
        end
    end

    // sequencer and controller state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            go_reg       <= 1'b0;
            integ_reg    <= '0;
            last_err_reg <= '0;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            go_reg <= 1'b0;
            if (m_valid_reg && m_tready && state_reg != ST_OUT)
                m_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        if (s_tuser == pid_pkg::FUNC_RESET)
                        begin
                            integ_reg    <= '0;
                            last_err_reg <= '0;
                        end
                        else if (in_ivl == '0)
                            state_reg <= ST_OUT;
                        else
                        begin
                            state_reg <= ST_DIV;
                            go_reg    <= 1'b1;
                        end
                    end
                end
                ST_DIV:
                    if (div_done)
                    begin
                        state_reg <= ST_MEI;
                        go_reg    <= 1'b1;
                    end
                ST_MEI:
                    if (mul_done)
                        state_reg <= ST_CAND;
                ST_CAND:
                begin
                    state_reg <= ST_MP;
                    go_reg    <= 1'b1;
                end
                ST_MP:
                    if (mul_done)
                    begin
                        state_reg <= ST_MD;
                        go_reg    <= 1'b1;
                    end
                ST_MD:
                    if (mul_done)
                    begin
                        state_reg <= ST_MIC;
                        go_reg    <= 1'b1;
                    end
                ST_MIC:
                    if (mul_done)
                    begin
                        state_reg <= ST_MIO;
                        go_reg    <= 1'b1;
                    end
                ST_MIO:
                    if (mul_done)
                        state_reg <= ST_SUM;
                ST_SUM:
                    state_reg <= ST_DEC;
                ST_DEC:
                begin
                    if (keep)
                        integ_reg <= cand_reg;
                    last_err_reg <= e_reg;
                    state_reg    <= ST_CLAMP;
                end
                ST_CLAMP:
                    state_reg <= ST_OUT;
                ST_OUT:
                    if (out_free)
                    begin
                        m_valid_reg <= 1'b1;
                        state_reg   <= ST_IDLE;
                    end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            e_reg     <= in_e;
            diff_reg  <= DIFF_W'(in_e) - DIFF_W'(last_err_reg);
            ivl_reg   <= in_ivl;
            drive_reg <= '0;
            alim_reg  <= 1'b0;
        end
        if (state_reg == ST_DIV && div_done)
            d_reg <= d_sat;
        if (mul_done)
        begin
            if (state_reg == ST_MEI)
                ei_reg <= mul_res;
            if (state_reg == ST_MP)
                tp_reg <= mul_res;
            if (state_reg == ST_MD)
                td_reg <= mul_res;
            if (state_reg == ST_MIC)
                tic_reg <= mul_res;
            if (state_reg == ST_MIO)
                tio_reg <= mul_res;
        end
        if (state_reg == ST_CAND)
            cand_reg <= cand_c;
        if (state_reg == ST_SUM)
            sum_reg <= SUM_W'(tp_reg) + SUM_W'(td_reg);
        if (state_reg == ST_DEC)
            y_reg <= sum_reg + SUM_W'(keep ? tic_reg : tio_reg);
        if (state_reg == ST_CLAMP)
        begin
            if (y1 < lo_w)
            begin
                drive_reg <= min_reg;
                alim_reg  <= 1'b1;
            end
            else
            begin
                drive_reg <= Q_W'(y1);
                alim_reg  <= c1;
            end
        end
        if (state_reg == ST_OUT && out_free)
        begin
            m_data_reg <= drive_reg;
            m_user_reg <= alim_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

    // multiplier finishes only in a multiply step
    a_mul_state: assert property (@(posedge clk) disable iff (!rst_n)
        mul_done |-> (state_reg == ST_MEI || state_reg == ST_MP || state_reg == ST_MD ||
                      state_reg == ST_MIC || state_reg == ST_MIO))
        else $error("multiplier done outside a multiply step");

    // divider finishes only in the divide step
    a_div_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == ST_DIV)
        else $error("divider done outside the divide step");

    // a reset request clears the integral and the previous error
    a_reset_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && s_tuser == pid_pkg::FUNC_RESET) |=> (integ_reg == '0 && last_err_reg == '0))
        else $error("reset request did not clear state");

    // a result is never overwritten while pending
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (m_valid_reg && !m_tready) |=> (m_valid_reg && $stable(m_data_reg)))
        else $error("pending result lost");

endmodule
